// ----- hdl/bsf_pkg.sv -----
// Shared types, constants and helpers for the breakable spring force core.
// Used by every module in this folder; depends on nothing.
package bsf_pkg;

	typedef struct packed {
		logic load;
		logic step;
	} bsf_ctl_t;

	localparam logic [1:0] REG_REST_LENGTH  = 2'd0;
	localparam logic [1:0] REG_STIFFNESS    = 2'd1;
	localparam logic [1:0] REG_BREAK_FACTOR = 2'd2;

	localparam logic [31:0] REST_LENGTH_RST  = 32'd65536;
	localparam logic [15:0] STIFFNESS_RST    = 16'd256;
	localparam logic [15:0] BREAK_FACTOR_RST = 16'd16384;

	localparam int MCAND_W = 49;
	localparam int MPLIER_W = 32;
	localparam int PROD_W = 81;
	localparam int RAD_W = 65;
	localparam int LEN_W = 33;
	localparam int QUO_W = 41;

	localparam logic [5:0] SQ_LAST = 6'd31;
	localparam logic [5:0] RT_LAST = 6'd32;
	localparam logic [5:0] KB_LAST = 6'd15;
	localparam logic [5:0] MA_LAST = 6'd31;
	localparam logic [5:0] DV_LAST = 6'd40;

	function automatic logic [31:0] bsf_sat(input logic [40:0] q, input logic neg);
		logic [40:0] nq;
		logic [31:0] r;
		nq = 41'd0 - q;
		if (q == 41'd0) begin
			r = 32'd0;
		end else if (neg) begin
			r = (q >= 41'h0_8000_0000) ? 32'h8000_0000 : nq[31:0];
		end else begin
			r = (q > 41'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
		end
		return r;
	endfunction

endpackage

// ----- hdl/bsf_mul.sv -----
// Bit-serial shift-add multiplier, one multiplier bit per cycle while step is set, MSB first.
// Depends on bsf_pkg for the control struct and widths.
module bsf_mul (
	input  logic                           clk,
	input  bsf_pkg::bsf_ctl_t              ctl,
	input  logic [bsf_pkg::MCAND_W-1:0]    mcand,
	input  logic [bsf_pkg::MPLIER_W-1:0]   mplier,
	output logic [bsf_pkg::PROD_W-1:0]     prod
);

	logic [bsf_pkg::MCAND_W-1:0]  mc_q;
	logic [bsf_pkg::MPLIER_W-1:0] mp_q;
	logic [bsf_pkg::PROD_W-1:0]   acc_q;
	logic [bsf_pkg::PROD_W-1:0]   addend;

	assign addend = mp_q[bsf_pkg::MPLIER_W-1]
		? {{(bsf_pkg::PROD_W-bsf_pkg::MCAND_W){1'b0}}, mc_q} : '0;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			mc_q  <= mcand;
			mp_q  <= mplier;
			acc_q <= '0;
		end else if (ctl.step) begin
			acc_q <= {acc_q[bsf_pkg::PROD_W-2:0], 1'b0} + addend;
			mp_q  <= {mp_q[bsf_pkg::MPLIER_W-2:0], 1'b0};
		end
	end

	assign prod = acc_q;

endmodule

// ----- hdl/bsf_sqrt.sv -----
// Restoring integer square root, one root bit per cycle while step is set (33 steps).
// Depends on bsf_pkg for the control struct and widths.
module bsf_sqrt (
	input  logic                        clk,
	input  bsf_pkg::bsf_ctl_t           ctl,
	input  logic [bsf_pkg::RAD_W-1:0]   radicand,
	output logic [bsf_pkg::LEN_W-1:0]   root
);

	logic [65:0] rad_q;
	logic [33:0] rem_q;
	logic [32:0] root_q;
	logic [35:0] rem_ext;
	logic [35:0] trial;
	logic [35:0] diff;
	logic        ge;

	always_comb begin
		rem_ext = {rem_q, rad_q[65:64]};
		trial   = {1'b0, root_q, 2'b01};
		diff    = rem_ext - trial;
		ge      = rem_ext >= trial;
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rad_q  <= {1'b0, radicand};
			rem_q  <= '0;
			root_q <= '0;
		end else if (ctl.step) begin
			rad_q  <= {rad_q[63:0], 2'b00};
			rem_q  <= ge ? diff[33:0] : rem_ext[33:0];
			root_q <= {root_q[31:0], ge};
		end
	end

	assign root = root_q;

endmodule

// ----- hdl/bsf_div.sv -----
// Restoring divider, one quotient bit per cycle while step is set (41 steps).
// The quotient must fit 41 bits. Depends on bsf_pkg.
module bsf_div (
	input  logic                         clk,
	input  bsf_pkg::bsf_ctl_t            ctl,
	input  logic [bsf_pkg::PROD_W-1:0]   numer,
	input  logic [bsf_pkg::QUO_W-1:0]    denom,
	output logic [bsf_pkg::QUO_W-1:0]    quo
);

	logic [40:0] rem_q;
	logic [40:0] num_q;
	logic [40:0] den_q;
	logic [40:0] quo_q;
	logic [41:0] r2;
	logic [41:0] diff;
	logic        ge;

	always_comb begin
		r2   = {rem_q, num_q[40]};
		diff = r2 - {1'b0, den_q};
		ge   = r2 >= {1'b0, den_q};
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rem_q <= {1'b0, numer[80:41]};
			num_q <= numer[40:0];
			den_q <= denom;
			quo_q <= '0;
		end else if (ctl.step) begin
			rem_q <= ge ? diff[40:0] : r2[40:0];
			num_q <= {num_q[39:0], 1'b0};
			quo_q <= {quo_q[39:0], ge};
		end
	end

	assign quo = quo_q;

endmodule

// ----- hdl/breakable_spring_force_2d_core.sv -----
// Breakable spring force core: one result per input transfer.
// Intact springs run the bit-serial multiplies (32+16+16+32), the 33-step square
// root, the break check and the 41-step dividers; the breaking step ends at the
// check, an already broken spring after the root. Input is taken only in idle,
// once the previous result is registered. Reset clears the broken flag and loads
// the default registers; the output register holds its result until transferred.
module breakable_spring_force_2d_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] first_x,
	input  logic signed [31:0] first_y,
	input  logic signed [31:0] second_x,
	input  logic signed [31:0] second_y,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] force_x,
	output logic signed [31:0] force_y,
	output logic [31:0]        current_length,
	output logic               is_broken
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_SQ_LD  = 4'd1;
	localparam logic [3:0] S_SQ_RUN = 4'd2;
	localparam logic [3:0] S_RT_LD  = 4'd3;
	localparam logic [3:0] S_RT_RUN = 4'd4;
	localparam logic [3:0] S_KP_LD  = 4'd5;
	localparam logic [3:0] S_KP_RUN = 4'd6;
	localparam logic [3:0] S_BP_LD  = 4'd7;
	localparam logic [3:0] S_BP_RUN = 4'd8;
	localparam logic [3:0] S_CHK    = 4'd9;
	localparam logic [3:0] S_MA_LD  = 4'd10;
	localparam logic [3:0] S_MA_RUN = 4'd11;
	localparam logic [3:0] S_DV_LD  = 4'd12;
	localparam logic [3:0] S_DV_RUN = 4'd13;
	localparam logic [3:0] S_FIN    = 4'd14;

	logic [3:0]  state_q;
	logic [5:0]  cnt_q;
	logic [31:0] rl_q;
	logic [15:0] k_q;
	logic [15:0] b_q;
	logic        broken_q;
	logic        stretch_q;
	logic [32:0] dx_q;
	logic [32:0] dy_q;
	logic [48:0] klen_q;
	logic [47:0] krl_q;
	logic [48:0] mk_q;

	logic        out_valid_q;
	logic [31:0] fx_q;
	logic [31:0] fy_q;
	logic [31:0] len_out_q;
	logic        brk_out_q;

	bsf_pkg::bsf_ctl_t mul_ctl;
	bsf_pkg::bsf_ctl_t rt_ctl;
	bsf_pkg::bsf_ctl_t dv_ctl;

	logic [48:0] mc0;
	logic [48:0] mc1;
	logic [31:0] mp0;
	logic [31:0] mp1;
	logic [80:0] prod0;
	logic [80:0] prod1;
	logic [32:0] len;
	logic [40:0] q0;
	logic [40:0] q1;

	logic [32:0] ax;
	logic [32:0] ay;
	logic [64:0] radicand;
	logic [54:0] lhs1;
	logic [54:0] rhs1;
	logic [54:0] lhs2;
	logic [54:0] rhs2;
	logic        brk_now;
	logic        stretch;
	logic        out_free;
	logic        cnt_done;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign out_free  = !out_valid_q || out_ready;
	assign cnt_done  = (cnt_q == 6'd0);

	always_comb begin
		ax       = dx_q[32] ? (33'd0 - dx_q) : dx_q;
		ay       = dy_q[32] ? (33'd0 - dy_q) : dy_q;
		radicand = {1'b0, prod0[63:0]} + {1'b0, prod1[63:0]};
		stretch  = len > {1'b0, rl_q};
		lhs1     = {klen_q, 6'b0};
		rhs1     = {5'b0, prod0[47:0], 2'b0} + {7'b0, prod0[47:0]};
		lhs2     = {krl_q, 7'b0};
		rhs2     = {3'b0, prod1[48:0], 3'b0} - {6'b0, prod1[48:0]};
		brk_now  = broken_q || (len == '0) || (lhs1 > rhs1) || (lhs2 > rhs2);
	end

	always_comb begin
		mul_ctl.load = (state_q == S_SQ_LD) || (state_q == S_KP_LD)
			|| (state_q == S_BP_LD) || (state_q == S_MA_LD);
		mul_ctl.step = (state_q == S_SQ_RUN) || (state_q == S_KP_RUN)
			|| (state_q == S_BP_RUN) || (state_q == S_MA_RUN);
		rt_ctl.load  = (state_q == S_RT_LD);
		rt_ctl.step  = (state_q == S_RT_RUN);
		dv_ctl.load  = (state_q == S_DV_LD);
		dv_ctl.step  = (state_q == S_DV_RUN);
	end

	always_comb begin
		case (state_q)
			S_SQ_LD: begin
				mc0 = {17'b0, ax[31:0]};
				mp0 = ax[31:0];
				mc1 = {17'b0, ay[31:0]};
				mp1 = ay[31:0];
			end
			S_KP_LD: begin
				mc0 = {16'b0, len};
				mp0 = {k_q, 16'b0};
				mc1 = {17'b0, rl_q};
				mp1 = {k_q, 16'b0};
			end
			S_BP_LD: begin
				mc0 = {17'b0, rl_q};
				mp0 = {b_q, 16'b0};
				mc1 = {16'b0, len};
				mp1 = {b_q, 16'b0};
			end
			S_MA_LD: begin
				mc0 = mk_q;
				mp0 = ax[31:0];
				mc1 = mk_q;
				mp1 = ay[31:0];
			end
			default: begin
				mc0 = '0;
				mp0 = '0;
				mc1 = '0;
				mp1 = '0;
			end
		endcase
	end

	bsf_mul u_mul0 (.clk(clk), .ctl(mul_ctl), .mcand(mc0), .mplier(mp0), .prod(prod0));
	bsf_mul u_mul1 (.clk(clk), .ctl(mul_ctl), .mcand(mc1), .mplier(mp1), .prod(prod1));

	bsf_sqrt u_sqrt (.clk(clk), .ctl(rt_ctl), .radicand(radicand), .root(len));

	bsf_div u_div0 (.clk(clk), .ctl(dv_ctl), .numer(prod0), .denom({len, 8'b0}), .quo(q0));
	bsf_div u_div1 (.clk(clk), .ctl(dv_ctl), .numer(prod1), .denom({len, 8'b0}), .quo(q1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rl_q <= bsf_pkg::REST_LENGTH_RST;
			k_q  <= bsf_pkg::STIFFNESS_RST;
			b_q  <= bsf_pkg::BREAK_FACTOR_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				bsf_pkg::REG_REST_LENGTH:  rl_q <= cfg_data;
				bsf_pkg::REG_STIFFNESS:    k_q  <= cfg_data[15:0];
				bsf_pkg::REG_BREAK_FACTOR: b_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			broken_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_SQ_LD;
					end
				end
				S_SQ_LD: begin
					cnt_q   <= bsf_pkg::SQ_LAST;
					state_q <= S_SQ_RUN;
				end
				S_SQ_RUN: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_done) begin
						state_q <= S_RT_LD;
					end
				end
				S_RT_LD: begin
					cnt_q   <= bsf_pkg::RT_LAST;
					state_q <= S_RT_RUN;
				end
				S_RT_RUN: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_done) begin
						state_q <= broken_q ? S_FIN : S_KP_LD;
					end
				end
				S_KP_LD: begin
					cnt_q   <= bsf_pkg::KB_LAST;
					state_q <= S_KP_RUN;
				end
				S_KP_RUN: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_done) begin
						state_q <= S_BP_LD;
					end
				end
				S_BP_LD: begin
					cnt_q   <= bsf_pkg::KB_LAST;
					state_q <= S_BP_RUN;
				end
				S_BP_RUN: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_done) begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					broken_q <= brk_now;
					state_q  <= brk_now ? S_FIN : S_MA_LD;
				end
				S_MA_LD: begin
					cnt_q   <= bsf_pkg::MA_LAST;
					state_q <= S_MA_RUN;
				end
				S_MA_RUN: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_done) begin
						state_q <= S_DV_LD;
					end
				end
				S_DV_LD: begin
					cnt_q   <= bsf_pkg::DV_LAST;
					state_q <= S_DV_RUN;
				end
				S_DV_RUN: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			dx_q <= {first_x[31], first_x} - {second_x[31], second_x};
			dy_q <= {first_y[31], first_y} - {second_y[31], second_y};
		end
		if (state_q == S_BP_LD) begin
			klen_q <= prod0[48:0];
			krl_q  <= prod1[47:0];
		end
		if (state_q == S_CHK) begin
			stretch_q <= stretch;
			mk_q      <= stretch ? (klen_q - {1'b0, krl_q}) : ({1'b0, krl_q} - klen_q);
		end
		if (state_q == S_FIN && out_free) begin
			fx_q      <= broken_q ? 32'd0 : bsf_pkg::bsf_sat(q0, stretch_q != dx_q[32]);
			fy_q      <= broken_q ? 32'd0 : bsf_pkg::bsf_sat(q1, stretch_q != dy_q[32]);
			len_out_q <= len[32] ? 32'hFFFF_FFFF : len[31:0];
			brk_out_q <= broken_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign force_x        = fx_q;
	assign force_y        = fy_q;
	assign current_length = len_out_q;
	assign is_broken      = brk_out_q;

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for breakable_spring_force_2d_core: drives particle pairs and
// register writes with random idling, predicts force, length and the broken flag.
// Depends on bsf_pkg and the core RTL only.
module testbench;

	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] COORD_MAX = 32'sh7FFF_FFFF;

	typedef struct packed {
		logic signed [31:0] first_x;
		logic signed [31:0] first_y;
		logic signed [31:0] second_x;
		logic signed [31:0] second_y;
	} spring_in_t;

	typedef struct packed {
		logic signed [31:0] force_x;
		logic signed [31:0] force_y;
		logic [31:0]        current_length;
		logic               is_broken;
	} spring_out_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [31:0]        cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic signed [31:0] first_x;
	logic signed [31:0] first_y;
	logic signed [31:0] second_x;
	logic signed [31:0] second_y;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] force_x;
	logic signed [31:0] force_y;
	logic [31:0]        current_length;
	logic               is_broken;

	logic [31:0] spring_rest_len = bsf_pkg::REST_LENGTH_RST;
	logic [15:0] spring_k = bsf_pkg::STIFFNESS_RST;
	logic [15:0] spring_b = bsf_pkg::BREAK_FACTOR_RST;
	logic        spring_broken = 1'b0;

	spring_out_t pending_responses[$];
	spring_out_t head_response;
	int          mismatches = 0;
	bit          steady = 1'b0;
	int          stall_left = 0;

	breakable_spring_force_2d_core DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.first_x        (first_x),
		.first_y        (first_y),
		.second_x       (second_x),
		.second_y       (second_y),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.force_x        (force_x),
		.force_y        (force_y),
		.current_length (current_length),
		.is_broken      (is_broken)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [32:0] root_floor(input logic [65:0] v);
		logic [32:0] r;
		logic [32:0] c;
		logic [65:0] sq;
		int i;
		r = '0;
		for (i = 32; i >= 0; i--) begin
			c = r | (33'd1 << i);
			sq = {33'd0, c} * {33'd0, c};
			if (sq <= v)
				r = c;
		end
		return r;
	endfunction

	function automatic bit overstressed(input logic [32:0] len);
		logic [63:0] k;
		logic [63:0] b;
		logic [63:0] rl;
		logic [63:0] l;
		k = 64'(spring_k);
		b = 64'(spring_b);
		rl = 64'(spring_rest_len);
		l = 64'(len);
		return len == 33'd0 || ((k * l) << 6) > (5 * b * rl) || ((k * rl) << 7) > (7 * b * l);
	endfunction

	function automatic logic [31:0] axis_force(input logic [32:0] len, input logic [32:0] acomp,
			input logic comp_neg);
		logic [32:0]  mag;
		logic [127:0] num;
		logic [127:0] den;
		logic [127:0] q;
		logic         stretch;
		logic         neg;
		stretch = len > {1'b0, spring_rest_len};
		mag = stretch ? len - {1'b0, spring_rest_len} : {1'b0, spring_rest_len} - len;
		num = 128'(mag) * 128'(spring_k) * 128'(acomp);
		den = 128'(len) << 8;
		q = num / den;
		neg = stretch != comp_neg;
		if (q == '0)
			return 32'd0;
		if (neg)
			return (q >= 128'h8000_0000) ? 32'h8000_0000 : 32'd0 - q[31:0];
		return (q > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
	endfunction

	function automatic spring_out_t spring_response(input spring_in_t s);
		logic signed [32:0] dx;
		logic signed [32:0] dy;
		logic [32:0]        ax;
		logic [32:0]        ay;
		logic [32:0]        len;
		logic [65:0]        sq_sum;
		spring_out_t        r;
		dx = {s.first_x[31], s.first_x} - {s.second_x[31], s.second_x};
		dy = {s.first_y[31], s.first_y} - {s.second_y[31], s.second_y};
		ax = dx[32] ? -dx : dx;
		ay = dy[32] ? -dy : dy;
		sq_sum = {33'd0, ax} * {33'd0, ax} + {33'd0, ay} * {33'd0, ay};
		len = root_floor(sq_sum);
		if (!spring_broken && overstressed(len))
			spring_broken = 1'b1;
		r.is_broken = spring_broken;
		r.current_length = len[32] ? 32'hFFFF_FFFF : len[31:0];
		r.force_x = spring_broken ? 32'sd0 : axis_force(len, ax, dx[32]);
		r.force_y = spring_broken ? 32'sd0 : axis_force(len, ay, dy[32]);
		return r;
	endfunction

	// Lengths that keep the spring intact under the given registers
	function automatic void intact_window(input logic [31:0] rl, input logic [15:0] k,
			input logic [15:0] b, output longint lo, output longint hi);
		longint kk;
		longint bb;
		longint rr;
		kk = k;
		bb = b;
		rr = rl;
		if (bb == 0)
			lo = (kk * rr == 0) ? 1 : longint'(COORD_MAX) + 1;
		else
			lo = (128 * kk * rr + 7 * bb - 1) / (7 * bb);
		if (lo < 1)
			lo = 1;
		hi = (kk == 0) ? longint'(COORD_MAX) : (5 * bb * rr) / (64 * kk);
		if (hi > longint'(COORD_MAX))
			hi = longint'(COORD_MAX);
	endfunction

	function automatic logic signed [31:0] place_end(input longint f, input longint d);
		longint v;
		v = f - d;
		if (v > longint'(COORD_MAX) || v < longint'(COORD_MIN))
			v = f + d;
		return v[31:0];
	endfunction

	function automatic spring_in_t offset_pair(input longint dx, input longint dy);
		spring_in_t s;
		longint     fx;
		longint     fy;
		fx = longint'($signed($urandom));
		fy = longint'($signed($urandom));
		s.first_x = fx[31:0];
		s.first_y = fy[31:0];
		s.second_x = place_end(fx, dx);
		s.second_y = place_end(fy, dy);
		return s;
	endfunction

	function automatic logic signed [31:0] edge_coord();
		case ($urandom_range(0, 4))
		0: return COORD_MIN;
		1: return COORD_MAX;
		2: return 32'sd0;
		default: return $urandom;
		endcase
	endfunction

	function automatic spring_in_t loose_pair();
		if ($urandom_range(0, 1) == 0)
			return '{edge_coord(), edge_coord(), edge_coord(), edge_coord()};
		return offset_pair(longint'($signed($urandom)) >>> $urandom_range(0, 31),
			longint'($signed($urandom)) >>> $urandom_range(0, 31));
	endfunction

	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
		mismatches++;
	endtask

	task automatic release_input();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic await_responses();
		while (pending_responses.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_item(input spring_in_t s);
		int gap;
		gap = steady ? 0 : draw_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		first_x <= s.first_x;
		first_y <= s.first_y;
		second_x <= s.second_x;
		second_y <= s.second_y;
		do @(posedge clk); while (!in_ready);
		pending_responses.push_back(spring_response(s));
	endtask

	task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
		release_input();
		await_responses();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (index)
		bsf_pkg::REG_REST_LENGTH: spring_rest_len = value;
		bsf_pkg::REG_STIFFNESS: spring_k = value[15:0];
		bsf_pkg::REG_BREAK_FACTOR: spring_b = value[15:0];
		default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_spring(input logic [31:0] rl, input logic [15:0] k, input logic [15:0] b);
		write_reg(bsf_pkg::REG_REST_LENGTH, rl);
		write_reg(bsf_pkg::REG_STIFFNESS, {16'd0, k});
		write_reg(bsf_pkg::REG_BREAK_FACTOR, {16'd0, b});
	endtask

	task automatic test_intact_directed();
		longint lo;
		longint hi;
		set_spring(bsf_pkg::REST_LENGTH_RST, bsf_pkg::STIFFNESS_RST,
			bsf_pkg::BREAK_FACTOR_RST);
		intact_window(spring_rest_len, spring_k, spring_b, lo, hi);
		send_item(offset_pair(-65536, 0));
		send_item(offset_pair(0, 131072));
		send_item(offset_pair(-40000, 0));
		send_item('{COORD_MAX, COORD_MIN, COORD_MAX - 32'sd100000, COORD_MIN + 32'sd70000});
		send_item(offset_pair(lo, 0));
		send_item(offset_pair(0, -hi));
		write_reg(REG_UNUSED, 32'h0000_0001);
		send_item(offset_pair(65536, 65536));
	endtask

	task automatic test_zero_stiffness();
		set_spring(bsf_pkg::REST_LENGTH_RST, 16'd0, 16'd0);
		send_item('{COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX});
		send_item('{COORD_MAX, 32'sd0, COORD_MIN, 32'sd0});
		send_item(offset_pair(1, 0));
	endtask

	task automatic test_random_intact();
		longint      lo;
		longint      hi;
		longint      t;
		longint      dx;
		longint      dy;
		logic [31:0] rl;
		logic [15:0] k;
		logic [15:0] b;
		spring_in_t  s;
		int          phase;
		int          n;
		for (phase = 0; phase < 19; phase++) begin
			case (phase)
			0: begin
				rl = bsf_pkg::REST_LENGTH_RST;
				k = bsf_pkg::STIFFNESS_RST;
				b = bsf_pkg::BREAK_FACTOR_RST;
			end
			1: begin
				rl = 32'hFFFF_FFFF;
				k = 16'd1;
				b = 16'hFFFF;
			end
			2: begin
				rl = 32'd1;
				k = 16'd1;
				b = 16'd16384;
			end
			3: begin
				rl = $urandom;
				k = 16'd0;
				b = 16'd0;
			end
			default: begin
				do begin
					rl = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(1, 1 << 20);
					k = $urandom_range(1, 4000);
					b = $urandom;
					intact_window(rl, k, b, lo, hi);
				end while (hi < lo + 2);
			end
			endcase
			set_spring(rl, k, b);
			intact_window(rl, k, b, lo, hi);
			steady = (phase % 5 == 4);
			for (n = 0; n < 100; n++) begin
				if (k == 16'd0) begin
					s = loose_pair();
					if (s.first_x == s.second_x && s.first_y == s.second_y)
						s.second_x = s.second_x ^ 32'sd1;
					send_item(s);
				end else begin
					if ($urandom_range(0, 7) == 0) begin
						dx = ($urandom_range(0, 1) == 1) ? lo : hi;
						dy = 0;
					end else begin
						t = $urandom_range(32'(lo + 1), 32'(hi));
						dx = $urandom_range(0, 32'(t));
						dy = longint'(root_floor(66'(t * t - dx * dx)));
					end
					if ($urandom_range(0, 1) == 1)
						dx = -dx;
					if ($urandom_range(0, 1) == 1)
						dy = -dy;
					if ($urandom_range(0, 1) == 1)
						send_item(offset_pair(dy, dx));
					else
						send_item(offset_pair(dx, dy));
				end
			end
		end
		steady = 1'b0;
	endtask

	task automatic test_breaking_step();
		longint lo;
		longint hi;
		set_spring(bsf_pkg::REST_LENGTH_RST, bsf_pkg::STIFFNESS_RST,
			bsf_pkg::BREAK_FACTOR_RST);
		intact_window(spring_rest_len, spring_k, spring_b, lo, hi);
		if ($urandom_range(0, 1) == 1)
			send_item(offset_pair(hi + 1, 0));
		else
			send_item(offset_pair(0, lo - 1));
	endtask

	task automatic test_broken_spring();
		send_item(offset_pair(0, 0));
		write_reg(bsf_pkg::REG_REST_LENGTH, 32'd0);
		send_item(offset_pair(65536, 0));
		write_reg(bsf_pkg::REG_STIFFNESS, 32'h0000_FFFF);
		write_reg(bsf_pkg::REG_BREAK_FACTOR, 32'h0000_FFFF);
		send_item('{COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN});
	endtask

	task automatic test_random_broken();
		spring_in_t s;
		int         n;
		for (n = 0; n < 120; n++) begin
			if (n % 30 == 29)
				write_reg(2'($urandom), $urandom);
			s = loose_pair();
			if ($urandom_range(0, 9) == 0) begin
				s.second_x = s.first_x;
				s.second_y = s.first_y;
			end
			send_item(s);
		end
	endtask

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left == 0 && !steady && $urandom_range(0, 7) == 0)
				stall_left = draw_gap();
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_responses.size() == 0) begin
				report_mismatch("result with no input", current_length, 32'd0);
			end else begin
				head_response = pending_responses.pop_front();
				if (force_x !== head_response.force_x)
					report_mismatch("force_x", force_x, head_response.force_x);
				if (force_y !== head_response.force_y)
					report_mismatch("force_y", force_y, head_response.force_y);
				if (current_length !== head_response.current_length)
					report_mismatch("current_length", current_length,
						head_response.current_length);
				if (is_broken !== head_response.is_broken)
					report_mismatch("is_broken", {31'd0, is_broken},
						{31'd0, head_response.is_broken});
			end
		end
	end

	initial begin
		#30_000_000;
		$display("FAIL breakable_spring_force_2d_core");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = bsf_pkg::REG_REST_LENGTH;
		cfg_data = 32'd0;
		in_valid = 1'b0;
		first_x = 32'sd0;
		first_y = 32'sd0;
		second_x = 32'sd0;
		second_y = 32'sd0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_intact_directed();
		test_zero_stiffness();
		test_random_intact();
		test_breaking_step();
		test_broken_spring();
		test_random_broken();

		release_input();
		await_responses();
		repeat (250) @(posedge clk);
		if (mismatches == 0)
			$display("PASS breakable_spring_force_2d_core");
		else
			$display("FAIL breakable_spring_force_2d_core");
		$finish;
	end

endmodule
